/* rtl/stable_priority_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue unit
// Shared property shapes, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the stable priority queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;
    localparam int WORD_W = 32;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_QUERY = 2'd0;
    localparam func_t FUNC_ENQ   = 2'd1;
    localparam func_t FUNC_DEQ   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_empty;
        logic is_full;
    } status_t;

    typedef struct packed {
        logic [OCC_W-1:0]  occupancy;
        logic              is_full;
        logic              is_empty;
        logic [WORD_W-1:0] head_payload;
        logic [WORD_W-1:0] head_priority;
        logic [WORD_W-1:0] deq_payload;
        logic              deq_valid;
        logic              enq_accepted;
    } result_t;

endpackage

`default_nettype wire

/* rtl/stable_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded stable priority queue of priority/payload pairs, highest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_): one item per operation. s_tuser carries the operation
//   (query, enqueue, dequeue head; the unused code acts as a query), s_tdata
//   the priority and payload of a pair to enqueue.
//   Output stream (m_): exactly one result item per input item, in order,
//   reporting enqueue/dequeue outcome and the queue state after the step.
//   Pairs of equal priority leave in arrival order.
// Sequencing:
//   An item is taken in the idle state and run in the execute state, where its
//   result is registered. The unit takes no new item until it is through with
//   the last: the controller takes each item in idle and runs it in execute,
//   leaving only once the output register frees; the sorted store updates
//   all cells in parallel within the execute state.
// Reset:
//   aresetn (synchronous, active low) empties the queue and drops any held
//   result. Stored pairs are not cleared; only occupied cells are ever read.
// Stalls:
//   A finished result waits in the output register while m_tready is low;
//   the next item is still taken, then held in execute until the output
//   register frees, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_unit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input item stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // [31:0] priority_req, [63:32] payload
    input  wire logic [1:0]   s_tuser,   // [1:0] func
    // result item stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata    // [0] enq_accepted, [1] deq_valid,
                                         // [33:2] deq_payload, [65:34] head_priority,
                                         // [97:66] head_payload, [98] is_empty,
                                         // [99] is_full, [104:100] occupancy,
                                         // [111:105] zero
);

    spq_pkg::cmd_t    cmd;
    spq_pkg::status_t status;
    spq_pkg::result_t result;

    // handshake and sequencing
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // sorted store and result register
    spq_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_func     (s_tuser),
        .in_priority (s_tdata[31:0]),
        .in_payload  (s_tdata[63:32]),
        .status      (status),
        .result      (result)
    );

    // pack result fields, lowest first, pad to whole bytes
    assign m_tdata = {7'd0,
                      result.occupancy,
                      result.is_full,
                      result.is_empty,
                      result.head_payload,
                      result.head_priority,
                      result.deq_payload,
                      result.deq_valid,
                      result.enq_accepted};

endmodule

`default_nettype wire

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: takes an item, runs it, holds the result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire spq_pkg::status_t status,
    output spq_pkg::cmd_t         cmd
);

    spq_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = spq_pkg::ST_EXEC;
            end
            spq_pkg::ST_EXEC: begin
                if (slot_free) state_next = spq_pkg::ST_IDLE;
            end
            default: state_next = spq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            spq_pkg::ST_EXEC: begin
                cmd.commit = slot_free;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.commit)    out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
        else               out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

`include "stable_priority_queue_unit_assert.svh"

    `SPQ_ASSERT_NOW(a_commit_slot, cmd.commit, !out_valid_reg || m_tready, "commit over held result")
    `SPQ_ASSERT_NOW(a_flags_excl, 1'b1, !(status.is_empty && status.is_full), "empty and full together")

endmodule

`default_nettype wire

/* rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted shift-register store of priority/payload pairs and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire spq_pkg::cmd_t               cmd,
    input  wire spq_pkg::func_t              in_func,
    input  wire logic [spq_pkg::WORD_W-1:0]  in_priority,
    input  wire logic [spq_pkg::WORD_W-1:0]  in_payload,
    output spq_pkg::status_t                 status,
    output spq_pkg::result_t                 result
);

    localparam int D = spq_pkg::DEPTH;
    localparam int W = spq_pkg::WORD_W;

    spq_pkg::func_t            op_reg;
    logic [W-1:0]              pr_reg;
    logic [W-1:0]              pl_reg;
    logic [W-1:0]              prio_reg [D];
    logic [W-1:0]              data_reg [D];
    logic [W-1:0]              prio_next [D];
    logic [W-1:0]              data_next [D];
    logic [W-1:0]              up_prio [D];
    logic [W-1:0]              up_data [D];
    logic [W-1:0]              dn_prio [D];
    logic [W-1:0]              dn_data [D];
    logic [spq_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [D-1:0]              ge;
    logic [D-1:0]              prev_ge;
    logic                      enq_ok, deq_ok;
    spq_pkg::result_t          res_reg, res_next;

    // capture the item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_func;
            pr_reg <= in_priority;
            pl_reg <= in_payload;
        end
    end

    assign enq_ok = (op_reg == spq_pkg::FUNC_ENQ) && (cnt_reg != spq_pkg::CNT_W'(D));
    assign deq_ok = (op_reg == spq_pkg::FUNC_DEQ) && (cnt_reg != '0);

    // per-cell compare: cell keeps its pair when it ranks at or above the new one
    always_comb begin
        for (int i = 0; i < D; i++) begin
            ge[i] = (i < int'(cnt_reg)) && (prio_reg[i] >= pr_reg);
        end
        prev_ge[0] = 1'b1;
        for (int i = 1; i < D; i++) begin
            prev_ge[i] = ge[i-1];
        end
    end

    // neighbour taps
    always_comb begin
        up_prio[0] = pr_reg;
        up_data[0] = pl_reg;
        for (int i = 1; i < D; i++) begin
            up_prio[i] = prio_reg[i-1];
            up_data[i] = data_reg[i-1];
        end
        for (int i = 0; i < D - 1; i++) begin
            dn_prio[i] = prio_reg[i+1];
            dn_data[i] = data_reg[i+1];
        end
        dn_prio[D-1] = prio_reg[D-1];
        dn_data[D-1] = data_reg[D-1];
    end

    always_comb begin
        for (int i = 0; i < D; i++) begin
            prio_next[i] = prio_reg[i];
            data_next[i] = data_reg[i];
            if (enq_ok) begin
                if (!ge[i]) begin
                    if (prev_ge[i]) begin
                        prio_next[i] = pr_reg;
                        data_next[i] = pl_reg;
                    end else begin
                        prio_next[i] = up_prio[i];
                        data_next[i] = up_data[i];
                    end
                end
            end else if (deq_ok) begin
                prio_next[i] = dn_prio[i];
                data_next[i] = dn_data[i];
            end
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (enq_ok)      cnt_next = cnt_reg + 1'b1;
        else if (deq_ok) cnt_next = cnt_reg - 1'b1;
    end

    always_comb begin
        res_next.enq_accepted  = enq_ok;
        res_next.deq_valid     = deq_ok;
        res_next.deq_payload   = deq_ok ? data_reg[0] : '0;
        res_next.is_empty      = (cnt_next == '0);
        res_next.is_full       = (cnt_next == spq_pkg::CNT_W'(D));
        res_next.head_priority = res_next.is_empty ? '1 : prio_next[0];
        res_next.head_payload  = res_next.is_empty ? '0 : data_next[0];
        res_next.occupancy     = spq_pkg::OCC_W'(cnt_next);
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int i = 0; i < D; i++) begin
                prio_reg[i] <= prio_next[i];
                data_reg[i] <= data_next[i];
            end
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.commit) begin
            cnt_reg <= cnt_next;
        end
    end

    assign status.is_empty = (cnt_reg == '0);
    assign status.is_full  = (cnt_reg == spq_pkg::CNT_W'(D));
    assign result          = res_reg;

`include "stable_priority_queue_unit_assert.svh"

    `SPQ_ASSERT_NEXT(a_enq_count, cmd.commit && enq_ok, cnt_reg == spq_pkg::CNT_W'($past(cnt_reg) + 1'b1), "enqueue did not grow count")
    `SPQ_ASSERT_NEXT(a_deq_flag, cmd.commit && deq_ok, res_reg.deq_valid && (res_reg.deq_payload == $past(data_reg[0])), "dequeue result mismatch")
    `SPQ_ASSERT_NOW(a_sorted, cnt_reg >= spq_pkg::CNT_W'(2), prio_reg[0] >= prio_reg[1], "head pair out of order")
    `SPQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= spq_pkg::CNT_W'(D), "count beyond depth")

endmodule

`default_nettype wire
